FILE: rtl/core/hht_pkg.sv
// Shared types and constants for the HTTP head tokenizer.
// Depends on nothing; the top level uses it by scoped names.
package hht_pkg;

    // Character codes the tokenizer looks for.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // The status code field takes at most this many bytes.
    localparam logic [7:0] CODE_DIGITS = 8'd10;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    // Configuration register indexes.
    localparam logic [7:0] CFG_IS_RESPONSE   = 8'd0;
    localparam logic [7:0] CFG_METHOD_LIMIT  = 8'd1;
    localparam logic [7:0] CFG_VERSION_LIMIT = 8'd2;
    localparam logic [7:0] CFG_STATUS_LIMIT  = 8'd3;

    // Configuration reset values.
    localparam logic [7:0] METHOD_LIMIT_RST  = 8'd15;
    localparam logic [7:0] VERSION_LIMIT_RST = 8'd15;
    localparam logic [7:0] STATUS_LIMIT_RST  = 8'd63;

    // Token classes.
    localparam logic [2:0] TOK_DELIM  = 3'd0;
    localparam logic [2:0] TOK_FIELD1 = 3'd1;
    localparam logic [2:0] TOK_FIELD2 = 3'd2;
    localparam logic [2:0] TOK_FIELD3 = 3'd3;
    localparam logic [2:0] TOK_KEY    = 3'd4;
    localparam logic [2:0] TOK_VALUE  = 3'd5;
    localparam logic [2:0] TOK_DONE   = 3'd6;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG     = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE1    = 3'd2;
    localparam logic [2:0] ERR_NO_SPACE2    = 3'd3;
    localparam logic [2:0] ERR_NO_COLON     = 3'd4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_of_message;
    } hht_in_t;

    typedef struct packed {
        logic [7:0]         byte_out;
        logic [2:0]         token_class;
        logic               line_complete;
        logic               head_complete;
        logic [2:0]         error_code;
        logic signed [31:0] status_number;
    } hht_out_t;

endpackage

FILE: rtl/core/http_head_tokenizer.sv
// Top level of the HTTP head tokenizer: parse state, result register and skid stage.
// Depends on hht_pkg for the payload structs, character codes and token/error codes.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid / in_ready     | hht_pkg::hht_in_t  (one head byte)
//  out     | output    | out_valid / out_ready   | hht_pkg::hht_out_t (tagged byte)
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_index (8 bits), cfg_data (8 bits)
//
// Each accepted byte is registered in the result register, or in the skid register
// if a result is stalled; a byte can be accepted every cycle while the skid is empty.
// Each update is one pass of logic between the parse state and result registers.
// A skid register behind the result register lets one more byte be accepted while
// a result is stalled; in_ready drops only when that skid register is occupied.
// Reset restores the configuration defaults and the start-of-head parse state.
// Configuration writes are always taken, and are meant to be made while idle.
module http_head_tokenizer
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  hht_pkg::hht_in_t  in_data,

    output logic              out_valid,
    input  logic              out_ready,
    output hht_pkg::hht_out_t out_data,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    // Parser phase, one-hot. The start line has three fields; after the third
    // field ends early (CR or NUL) the rest of the line is ignored. Header lines
    // go through key, leading-space skip, value and ignored tail.
    typedef enum logic [7:0] {
        PH_F1    = 8'b0000_0001,
        PH_F2    = 8'b0000_0010,
        PH_F3    = 8'b0000_0100,
        PH_F3END = 8'b0000_1000,
        PH_KEY   = 8'b0001_0000,
        PH_VSKIP = 8'b0010_0000,
        PH_VAL   = 8'b0100_0000,
        PH_VEND  = 8'b1000_0000
    } phase_t;

    // Configuration registers.
    logic       is_response_reg;
    logic [7:0] method_limit_reg;
    logic [7:0] version_limit_reg;
    logic [7:0] status_limit_reg;

    // Parse state.
    phase_t      phase_reg,   phase_next;
    logic [1:0]  nl_run_reg,  nl_run_next;
    logic [7:0]  count_reg,   count_next;
    logic [31:0] acc_reg,     acc_next;
    logic        stopped_reg, stopped_next;

    // Output register and skid stage.
    logic              out_valid_reg;
    hht_pkg::hht_out_t out_data_reg;
    logic              skid_valid_reg;
    hht_pkg::hht_out_t skid_data_reg;

    hht_pkg::hht_out_t result;
    logic              in_fire;
    logic              out_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes. Indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_response_reg   <= 1'b0;
            method_limit_reg  <= hht_pkg::METHOD_LIMIT_RST;
            version_limit_reg <= hht_pkg::VERSION_LIMIT_RST;
            status_limit_reg  <= hht_pkg::STATUS_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hht_pkg::CFG_IS_RESPONSE:   is_response_reg   <= cfg_data[0];
                hht_pkg::CFG_METHOD_LIMIT:  method_limit_reg  <= cfg_data;
                hht_pkg::CFG_VERSION_LIMIT: version_limit_reg <= cfg_data;
                hht_pkg::CFG_STATUS_LIMIT:  status_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-byte parse step. A start-of-message byte sees the cleared state.
    always_comb
    begin
        logic [7:0]  b;
        logic        is_cr;
        logic        is_lf;
        logic        is_sp;
        phase_t      cur_phase;
        logic [1:0]  cur_nl;
        logic [7:0]  cur_count;
        logic [31:0] cur_acc;
        logic        cur_stopped;
        logic [7:0]  limit;
        logic [2:0]  cls;
        logic        lc;
        logic        hc;
        logic [2:0]  err;

        b     = in_data.byte_in;
        is_cr = (b == hht_pkg::CHAR_CR);
        is_lf = (b == hht_pkg::CHAR_LF);
        is_sp = (b == hht_pkg::CHAR_SPACE);

        if (in_data.start_of_message)
        begin
            cur_phase   = PH_F1;
            cur_nl      = 2'd0;
            cur_count   = 8'd0;
            cur_acc     = 32'd0;
            cur_stopped = 1'b0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_nl      = nl_run_reg;
            cur_count   = count_reg;
            cur_acc     = acc_reg;
            cur_stopped = stopped_reg;
        end

        phase_next   = cur_phase;
        nl_run_next  = cur_nl;
        count_next   = cur_count;
        acc_next     = cur_acc;
        stopped_next = cur_stopped;
        limit        = 8'd0;
        cls          = hht_pkg::TOK_DELIM;
        lc           = 1'b0;
        hc           = 1'b0;
        err          = hht_pkg::ERR_NONE;

        if (cur_stopped)
        begin
            cls = (is_cr || is_lf) ? hht_pkg::TOK_DELIM : hht_pkg::TOK_DONE;
        end
        else
        begin
            // Count newlines separated only by CRs; the second one ends the head.
            if (is_lf)
            begin
                if (cur_nl != 2'd3)
                begin
                    nl_run_next = cur_nl + 2'd1;
                end
            end
            else if (!is_cr)
            begin
                nl_run_next = 2'd0;
            end

            if (is_lf && (nl_run_next >= 2'd2))
            begin
                hc           = 1'b1;
                stopped_next = 1'b1;
            end
            else
            begin
                unique case (cur_phase)
                    PH_F1:
                    begin
                        limit = is_response_reg ? version_limit_reg : method_limit_reg;
                        if (is_sp)
                        begin
                            phase_next = PH_F2;
                            count_next = 8'd0;
                        end
                        else if (is_lf)
                        begin
                            err = hht_pkg::ERR_NO_SPACE1;
                        end
                        else if (is_cr)
                        begin
                            cls = hht_pkg::TOK_DELIM;
                        end
                        else if (cur_count >= limit)
                        begin
                            err = hht_pkg::ERR_TOO_LONG;
                        end
                        else
                        begin
                            count_next = cur_count + 8'd1;
                            cls        = hht_pkg::TOK_FIELD1;
                        end
                    end
                    PH_F2:
                    begin
                        if (is_sp)
                        begin
                            phase_next = PH_F3;
                            count_next = 8'd0;
                        end
                        else if (is_lf)
                        begin
                            err = hht_pkg::ERR_NO_SPACE2;
                        end
                        else if (is_cr)
                        begin
                            cls = hht_pkg::TOK_DELIM;
                        end
                        else if (is_response_reg)
                        begin
                            if (cur_count >= hht_pkg::CODE_DIGITS)
                            begin
                                err = hht_pkg::ERR_TOO_LONG;
                            end
                            else
                            begin
                                // acc * 10 as two shifts, then add the digit value.
                                count_next = cur_count + 8'd1;
                                acc_next   = (cur_acc << 3) + (cur_acc << 1)
                                           + {24'd0, b} - {24'd0, hht_pkg::CHAR_ZERO};
                                cls        = hht_pkg::TOK_FIELD2;
                            end
                        end
                        else
                        begin
                            // The url has no limit; its count only saturates.
                            if (cur_count != hht_pkg::COUNT_MAX)
                            begin
                                count_next = cur_count + 8'd1;
                            end
                            cls = hht_pkg::TOK_FIELD2;
                        end
                    end
                    PH_F3:
                    begin
                        limit = is_response_reg ? status_limit_reg : version_limit_reg;
                        if (is_lf)
                        begin
                            lc         = 1'b1;
                            phase_next = PH_KEY;
                            count_next = 8'd0;
                        end
                        else if (is_cr || (b == hht_pkg::CHAR_NUL))
                        begin
                            phase_next = PH_F3END;
                        end
                        else if (cur_count >= limit)
                        begin
                            err = hht_pkg::ERR_TOO_LONG;
                        end
                        else
                        begin
                            count_next = cur_count + 8'd1;
                            cls        = hht_pkg::TOK_FIELD3;
                        end
                    end
                    PH_F3END:
                    begin
                        if (is_lf)
                        begin
                            lc         = 1'b1;
                            phase_next = PH_KEY;
                            count_next = 8'd0;
                        end
                    end
                    PH_KEY:
                    begin
                        if (b == hht_pkg::CHAR_COLON)
                        begin
                            phase_next = PH_VSKIP;
                        end
                        else if (is_lf)
                        begin
                            err = hht_pkg::ERR_NO_COLON;
                        end
                        else if (!is_cr)
                        begin
                            cls = hht_pkg::TOK_KEY;
                        end
                    end
                    PH_VSKIP:
                    begin
                        if (is_lf)
                        begin
                            lc         = 1'b1;
                            phase_next = PH_KEY;
                        end
                        else if (is_cr)
                        begin
                            phase_next = PH_VEND;
                        end
                        else if (!is_sp)
                        begin
                            phase_next = PH_VAL;
                            cls        = hht_pkg::TOK_VALUE;
                        end
                    end
                    PH_VAL:
                    begin
                        if (is_lf)
                        begin
                            lc         = 1'b1;
                            phase_next = PH_KEY;
                        end
                        else if (is_cr)
                        begin
                            phase_next = PH_VEND;
                        end
                        else
                        begin
                            cls = hht_pkg::TOK_VALUE;
                        end
                    end
                    PH_VEND:
                    begin
                        if (is_lf)
                        begin
                            lc         = 1'b1;
                            phase_next = PH_KEY;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_F1;
                    end
                endcase

                // Any error freezes the parse until the next message.
                if (err != hht_pkg::ERR_NONE)
                begin
                    stopped_next = 1'b1;
                    cls = (is_cr || is_lf) ? hht_pkg::TOK_DELIM : hht_pkg::TOK_DONE;
                end
            end
        end

        result.byte_out      = b;
        result.token_class   = cls;
        result.line_complete = lc;
        result.head_complete = hc;
        result.error_code    = err;
        result.status_number = $signed(acc_next);
    end

    // Parse state advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_F1;
            nl_run_reg  <= 2'd0;
            count_reg   <= 8'd0;
            acc_reg     <= 32'd0;
            stopped_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            nl_run_reg  <= nl_run_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result register with one skid entry. The skid entry fills only when a new
    // transaction arrives while the result register is held, and it drains into
    // the result register before any new input is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= result;
        end
    end

    // The skid entry is only ever used behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while the result register is empty");

    // An accepted byte that raises an error or ends the head stops the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ((result.error_code != hht_pkg::ERR_NONE) || result.head_complete))
        |=> stopped_reg)
        else $error("parser did not stop after an error or the end of the head");

    // The end of the head is never also a line close or an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.head_complete)
        |-> (!out_data.line_complete && (out_data.error_code == hht_pkg::ERR_NONE)))
        else $error("head end flagged together with a line close or error");

    // A byte that causes an error is tagged as a delimiter or as after-the-end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.error_code != hht_pkg::ERR_NONE))
        |-> ((out_data.token_class == hht_pkg::TOK_DELIM)
             || (out_data.token_class == hht_pkg::TOK_DONE)))
        else $error("error byte carries a field token class");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for http_head_tokenizer: streams directed and random HTTP heads
// through the byte channel and checks every tagged byte against a predictor of its own.
// Depends on hht_pkg and the http_head_tokenizer top level only.
module tb;

    // The slowest correct run is roughly 1800 transactions, each with the longest sender
    // gap and the longest receiver stall, plus one long hold; the limit is a few times that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_BYTES  = 240;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOWN_MAX    = 10;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Parse positions inside the head, mirrored from the block's behavior.
    typedef enum logic [2:0] {
        PH_FIELD1,
        PH_FIELD2,
        PH_FIELD3,
        PH_FIELD3_TAIL,
        PH_KEY,
        PH_VALUE_SKIP,
        PH_VALUE,
        PH_VALUE_TAIL
    } parse_phase_t;

    // Predicts the tag of every accepted byte and checks the tags that come out.
    // It keeps its own copy of the registers and of the parse state.
    class head_tagger;
        logic              is_response;
        logic [7:0]        method_limit;
        logic [7:0]        version_limit;
        logic [7:0]        status_limit;
        parse_phase_t      phase;
        logic [1:0]        newline_run;
        logic [7:0]        field_len;
        logic [31:0]       code_sum;
        logic              stopped;
        hht_pkg::hht_out_t tags_due[$];
        int                bytes_taken;
        int                tags_checked;
        int                mismatches;

        function new();
            is_response   = 1'b0;
            method_limit  = hht_pkg::METHOD_LIMIT_RST;
            version_limit = hht_pkg::VERSION_LIMIT_RST;
            status_limit  = hht_pkg::STATUS_LIMIT_RST;
            bytes_taken   = 0;
            tags_checked  = 0;
            mismatches    = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_FIELD1;
            newline_run = 2'd0;
            field_len   = 8'd0;
            code_sum    = 32'd0;
            stopped     = 1'b0;
        endfunction

        function void write_reg(logic [7:0] index, logic [7:0] data);
            case (index)
                hht_pkg::CFG_IS_RESPONSE:   is_response   = data[0];
                hht_pkg::CFG_METHOD_LIMIT:  method_limit  = data;
                hht_pkg::CFG_VERSION_LIMIT: version_limit = data;
                hht_pkg::CFG_STATUS_LIMIT:  status_limit  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return tags_due.size();
        endfunction

        // Works out the tag of one accepted byte and queues it.
        function void take_byte(hht_pkg::hht_in_t item);
            hht_pkg::hht_out_t tag;
            logic [7:0]        b;
            logic [7:0]        limit;
            logic              cr;
            logic              lf;
            b   = item.byte_in;
            cr  = (b == hht_pkg::CHAR_CR);
            lf  = (b == hht_pkg::CHAR_LF);
            tag = '0;
            tag.byte_out    = b;
            tag.token_class = hht_pkg::TOK_DELIM;
            tag.error_code  = hht_pkg::ERR_NONE;
            if (item.start_of_message)
                restart();
            if (stopped)
            begin
                tag.token_class = (cr || lf) ? hht_pkg::TOK_DELIM : hht_pkg::TOK_DONE;
            end
            else
            begin
                // CRs between newlines keep the run going; anything else breaks it.
                if (lf)
                begin
                    if (newline_run != 2'd3)
                        newline_run = newline_run + 2'd1;
                end
                else if (!cr)
                    newline_run = 2'd0;

                if (lf && newline_run >= 2'd2)
                begin
                    tag.head_complete = 1'b1;
                    stopped = 1'b1;
                end
                else
                begin
                    case (phase)
                        PH_FIELD1:
                        begin
                            limit = is_response ? version_limit : method_limit;
                            if (b == hht_pkg::CHAR_SPACE)
                            begin
                                phase     = PH_FIELD2;
                                field_len = 8'd0;
                            end
                            else if (lf)
                                tag.error_code = hht_pkg::ERR_NO_SPACE1;
                            else if (!cr)
                            begin
                                if (field_len >= limit)
                                    tag.error_code = hht_pkg::ERR_TOO_LONG;
                                else
                                begin
                                    field_len = field_len + 8'd1;
                                    tag.token_class = hht_pkg::TOK_FIELD1;
                                end
                            end
                        end
                        PH_FIELD2:
                        begin
                            if (b == hht_pkg::CHAR_SPACE)
                            begin
                                phase     = PH_FIELD3;
                                field_len = 8'd0;
                            end
                            else if (lf)
                                tag.error_code = hht_pkg::ERR_NO_SPACE2;
                            else if (!cr)
                            begin
                                if (is_response)
                                begin
                                    if (field_len >= hht_pkg::CODE_DIGITS)
                                        tag.error_code = hht_pkg::ERR_TOO_LONG;
                                    else
                                    begin
                                        field_len = field_len + 8'd1;
                                        code_sum  = code_sum * 32'd10 + {24'd0, b}
                                                  - {24'd0, hht_pkg::CHAR_ZERO};
                                        tag.token_class = hht_pkg::TOK_FIELD2;
                                    end
                                end
                                else
                                begin
                                    if (field_len != hht_pkg::COUNT_MAX)
                                        field_len = field_len + 8'd1;
                                    tag.token_class = hht_pkg::TOK_FIELD2;
                                end
                            end
                        end
                        PH_FIELD3:
                        begin
                            limit = is_response ? status_limit : version_limit;
                            if (lf)
                            begin
                                tag.line_complete = 1'b1;
                                phase     = PH_KEY;
                                field_len = 8'd0;
                            end
                            else if (cr || b == hht_pkg::CHAR_NUL)
                                phase = PH_FIELD3_TAIL;
                            else if (field_len >= limit)
                                tag.error_code = hht_pkg::ERR_TOO_LONG;
                            else
                            begin
                                field_len = field_len + 8'd1;
                                tag.token_class = hht_pkg::TOK_FIELD3;
                            end
                        end
                        PH_FIELD3_TAIL:
                        begin
                            if (lf)
                            begin
                                tag.line_complete = 1'b1;
                                phase     = PH_KEY;
                                field_len = 8'd0;
                            end
                        end
                        PH_KEY:
                        begin
                            if (b == hht_pkg::CHAR_COLON)
                                phase = PH_VALUE_SKIP;
                            else if (lf)
                                tag.error_code = hht_pkg::ERR_NO_COLON;
                            else if (!cr)
                                tag.token_class = hht_pkg::TOK_KEY;
                        end
                        PH_VALUE_SKIP:
                        begin
                            if (lf)
                            begin
                                tag.line_complete = 1'b1;
                                phase = PH_KEY;
                            end
                            else if (cr)
                                phase = PH_VALUE_TAIL;
                            else if (b != hht_pkg::CHAR_SPACE)
                            begin
                                phase = PH_VALUE;
                                tag.token_class = hht_pkg::TOK_VALUE;
                            end
                        end
                        PH_VALUE:
                        begin
                            if (lf)
                            begin
                                tag.line_complete = 1'b1;
                                phase = PH_KEY;
                            end
                            else if (cr)
                                phase = PH_VALUE_TAIL;
                            else
                                tag.token_class = hht_pkg::TOK_VALUE;
                        end
                        default:
                        begin
                            if (lf)
                            begin
                                tag.line_complete = 1'b1;
                                phase = PH_KEY;
                            end
                        end
                    endcase
                    if (tag.error_code != hht_pkg::ERR_NONE)
                    begin
                        stopped = 1'b1;
                        tag.token_class = (cr || lf) ? hht_pkg::TOK_DELIM
                                                     : hht_pkg::TOK_DONE;
                    end
                end
            end
            tag.status_number = code_sum;
            tags_due.push_back(tag);
            bytes_taken++;
        endfunction

        // Compares one result transaction with the oldest queued tag.
        function void match_tag(hht_pkg::hht_out_t got);
            hht_pkg::hht_out_t want;
            if (tags_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("tb: unexpected result, byte %h class %0d", got.byte_out,
                             got.token_class);
                return;
            end
            want = tags_due.pop_front();
            if (got.byte_out !== want.byte_out || got.token_class !== want.token_class ||
                got.line_complete !== want.line_complete ||
                got.head_complete !== want.head_complete ||
                got.error_code !== want.error_code ||
                got.status_number !== want.status_number)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                begin
                    $display("tb: mismatch at result %0d", tags_checked);
                    $display("    expected byte %h class %0d line %b head %b err %0d code %0d",
                             want.byte_out, want.token_class, want.line_complete,
                             want.head_complete, want.error_code, want.status_number);
                    $display("    actual   byte %h class %0d line %b head %b err %0d code %0d",
                             got.byte_out, got.token_class, got.line_complete,
                             got.head_complete, got.error_code, got.status_number);
                end
            end
            tags_checked++;
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    hht_pkg::hht_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    hht_pkg::hht_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = 8'd0;
    logic [7:0]        cfg_data  = 8'd0;

    head_tagger tagger;
    int         idle_pct    = 0;
    int         hold_left   = 0;
    bit         hold_done   = 1'b0;
    int         cycle_count = 0;
    logic [7:0] msg[$];

    http_head_tokenizer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle stretches: mostly short, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // A content byte that never acts as a separator. Separators come from the
    // structure of the head, so every bit of the byte still gets both values.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == hht_pkg::CHAR_SPACE || b == hht_pkg::CHAR_CR || b == hht_pkg::CHAR_LF ||
            b == hht_pkg::CHAR_COLON || b == hht_pkg::CHAR_NUL)
            b = CHAR_LOWER_A + 8'($urandom_range(25));
        return b;
    endfunction

    // Noise leans hard on the characters the parser reacts to.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0: return hht_pkg::CHAR_SPACE;
            1: return hht_pkg::CHAR_CR;
            2: return hht_pkg::CHAR_LF;
            3: return hht_pkg::CHAR_COLON;
            4: return hht_pkg::CHAR_NUL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Field length: mostly short, sometimes exactly at the limit, sometimes one
    // past it. Past-the-limit is rarer for wide limits to keep the run short.
    function automatic int pick_len(logic [7:0] lim);
        int odds;
        int r;
        odds = (lim > 8'd16) ? 2 : 8;
        r    = $urandom_range(99);
        if (r < odds)
            return int'(lim) + 1;
        if (r < 2 * odds)
            return int'(lim);
        return $urandom_range((lim < 8'd5) ? int'(lim) : 5);
    endfunction

    // Content bytes; a CR inside a start-line field or a key is tagged but not counted.
    function automatic void add_text(int len, bit cr_ok);
        repeat (len)
        begin
            msg.push_back(text_byte());
            if (cr_ok && $urandom_range(14) == 0)
                msg.push_back(hht_pkg::CHAR_CR);
        end
    endfunction

    function automatic void add_digits(int len);
        repeat (len)
        begin
            if ($urandom_range(9) == 0)
                msg.push_back(text_byte());
            else
                msg.push_back(hht_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    // Line endings: bare LF, CR LF, or a terminator followed by ignored bytes.
    // The third start-line field may also be cut short by a NUL.
    function automatic void end_line(bit nul_ok);
        case ($urandom_range(3))
            0: msg.push_back(hht_pkg::CHAR_LF);
            1:
            begin
                msg.push_back(hht_pkg::CHAR_CR);
                msg.push_back(hht_pkg::CHAR_LF);
            end
            2:
            begin
                msg.push_back(hht_pkg::CHAR_CR);
                add_text($urandom_range(3, 1), 1'b1);
                msg.push_back(hht_pkg::CHAR_LF);
            end
            default:
            begin
                msg.push_back(nul_ok ? hht_pkg::CHAR_NUL : hht_pkg::CHAR_CR);
                add_text($urandom_range(3, 1), 1'b1);
                msg.push_back(hht_pkg::CHAR_LF);
            end
        endcase
    endfunction

    // Bytes after the end of the head or after an error: tagged as done, or as delimiters if CR or LF.
    function automatic void add_tail();
        repeat ($urandom_range(2))
            msg.push_back(noise_byte());
    endfunction

    // Builds one head in msg for the current mode and limits. Most heads are well
    // formed; a few drop a space or a colon so that each missing-separator error is reached.
    function automatic void build_head();
        int         fault;
        int         lines;
        logic [7:0] lim1;
        logic [7:0] lim3;
        msg.delete();
        fault = $urandom_range(99);
        lim1  = tagger.is_response ? tagger.version_limit : tagger.method_limit;
        lim3  = tagger.is_response ? tagger.status_limit : tagger.version_limit;

        add_text(pick_len(lim1), 1'b1);
        if (fault < 4)
        begin
            msg.push_back(hht_pkg::CHAR_LF);
            add_tail();
            return;
        end
        msg.push_back(hht_pkg::CHAR_SPACE);

        if (tagger.is_response)
            add_digits(pick_len(hht_pkg::CODE_DIGITS));
        else
            add_text($urandom_range(8), 1'b1);
        if (fault < 8)
        begin
            msg.push_back(hht_pkg::CHAR_LF);
            add_tail();
            return;
        end
        msg.push_back(hht_pkg::CHAR_SPACE);

        add_text(pick_len(lim3), 1'b0);
        end_line(1'b1);

        // Header lines; a broken head ends with a key line that lacks its colon.
        lines = (fault < 12) ? $urandom_range(3, 1) : $urandom_range(3);
        for (int h = 0; h < lines; h++)
        begin
            if (fault < 12 && h == lines - 1)
            begin
                add_text($urandom_range(6, 1), 1'b1);
                msg.push_back(hht_pkg::CHAR_LF);
                add_tail();
                return;
            end
            add_text($urandom_range(6), 1'b1);
            msg.push_back(hht_pkg::CHAR_COLON);
            repeat ($urandom_range(2))
                msg.push_back(hht_pkg::CHAR_SPACE);
            add_text($urandom_range(8), 1'b0);
            end_line(1'b0);
        end

        // The blank line that closes the head, with or without CRs.
        case ($urandom_range(3))
            0: msg.push_back(hht_pkg::CHAR_LF);
            1:
            begin
                msg.push_back(hht_pkg::CHAR_CR);
                msg.push_back(hht_pkg::CHAR_CR);
                msg.push_back(hht_pkg::CHAR_LF);
            end
            default:
            begin
                msg.push_back(hht_pkg::CHAR_CR);
                msg.push_back(hht_pkg::CHAR_LF);
            end
        endcase
        add_tail();
    endfunction

    // Offers one byte and holds it until the block takes it. The valid stays high
    // into the next transaction unless an idle gap is drawn.
    task automatic send_byte(logic [7:0] value, logic sof);
        hht_pkg::hht_in_t item;
        item.byte_in          = value;
        item.start_of_message = sof;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tagger.take_byte(item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat (gap_len())
                @(posedge clk);
        end
    endtask

    // Sends msg. Now and then a start of message lands in the middle of a head.
    task automatic send_msg(bit sof_first);
        int cut;
        cut = ($urandom_range(49) == 0) ? $urandom_range(msg.size() - 1) : -1;
        foreach (msg[i])
            send_byte(msg[i], (i == 0 && sof_first) || i == cut);
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == 0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tagger.pending() != 0)
            @(posedge clk);
    endtask

    // Register writes are only made with nothing in flight. The valid stays high
    // across a batch and is lowered by the caller.
    task automatic write_reg(logic [7:0] index, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tagger.write_reg(index, data);
    endtask

    task automatic set_mode(logic resp, logic [7:0] meth, logic [7:0] ver,
                            logic [7:0] stat);
        // The upper bits of the mode register are don't-care and get random values.
        write_reg(hht_pkg::CFG_IS_RESPONSE, {7'($urandom_range(127)), resp});
        write_reg(hht_pkg::CFG_METHOD_LIMIT, meth);
        write_reg(hht_pkg::CFG_VERSION_LIMIT, ver);
        write_reg(hht_pkg::CFG_STATUS_LIMIT, stat);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: mostly whole heads, about one message in ten pure noise,
    // and about one in ten sent without a start of message on its first byte.
    task automatic run_phase(int idle);
        int stop_at;
        idle_pct = idle;
        stop_at  = tagger.bytes_taken + PHASE_BYTES;
        while (tagger.bytes_taken < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                msg.delete();
                repeat ($urandom_range(16, 4))
                    msg.push_back(noise_byte());
            end
            else
                build_head();
            send_msg($urandom_range(9) != 0);
        end
        wait_drained();
    endtask

    // Result side: checks every result transaction and draws its own stalls. Once,
    // partway through a phase with no idling, it holds off for a long stretch so
    // the skid stage fills and the block stops taking bytes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tagger.match_tag(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && tagger.bytes_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                hold_left = gap_len() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        tagger = new();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings. "\015" is CR.
        // A full request head with a header line, then a byte after the end.
        send_text("GET / H\015\nk: v\015\n\015\n");
        send_byte(8'hFF, 1'b0);
        // A newline before the first space, then one before the second space.
        send_text("X\n");
        send_text("a b\n");
        wait_drained();

        // Requests at the reset limits.
        set_mode(1'b0, hht_pkg::METHOD_LIMIT_RST, hht_pkg::VERSION_LIMIT_RST,
                 hht_pkg::STATUS_LIMIT_RST);
        run_phase(20);

        // Responses with small random limits.
        set_mode(1'b1, 8'($urandom_range(12, 2)), 8'($urandom_range(12, 2)),
                 8'($urandom_range(12, 2)));
        run_phase(35);

        // Widest limits, no idling; the long receiver hold falls in this phase.
        set_mode(1'b1, hht_pkg::COUNT_MAX, hht_pkg::COUNT_MAX, hht_pkg::COUNT_MAX);
        run_phase(0);

        // Narrowest nonzero limits with heavy idling.
        set_mode(1'b0, 8'd1, 8'd1, 8'd1);
        run_phase(50);

        // A write to an index with no register behind it, then zero limits,
        // which reject the first byte of a limited field.
        write_reg(8'($urandom_range(255, int'(hht_pkg::CFG_STATUS_LIMIT) + 1)),
                  8'($urandom_range(255)));
        set_mode(1'b1, 8'd0, 8'd0, 8'd0);
        run_phase(20);

        set_mode(1'b0, hht_pkg::COUNT_MAX, 8'd0, 8'd1);
        run_phase(10);

        set_mode(1'($urandom_range(1)), 8'($urandom_range(20, 1)),
                 8'($urandom_range(20, 1)), 8'($urandom_range(20, 1)));
        run_phase(25);

        // Everything has come back; the drain wait lets any stray result show before the verdict.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tagger.mismatches == 0 && tagger.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
